### rtl/oscmp_pkg.sv
// Package for the OSC message stream parser: byte roles, error codes,
// OSC marker characters and the result record. No dependencies.
package oscmp_pkg;

   // Role of each byte in the message.
   localparam logic [3:0] ROLE_ADDR        = 4'd0;
   localparam logic [3:0] ROLE_ADDR_PAD    = 4'd1;
   localparam logic [3:0] ROLE_TAG         = 4'd2;
   localparam logic [3:0] ROLE_TAG_PAD     = 4'd3;
   localparam logic [3:0] ROLE_NUM         = 4'd4;
   localparam logic [3:0] ROLE_STR         = 4'd5;
   localparam logic [3:0] ROLE_STR_PAD     = 4'd6;
   localparam logic [3:0] ROLE_BLOB_LEN    = 4'd7;
   localparam logic [3:0] ROLE_BLOB_DATA   = 4'd8;
   localparam logic [3:0] ROLE_BLOB_PAD    = 4'd9;
   localparam logic [3:0] ROLE_TRAILING    = 4'd10;
   localparam logic [3:0] ROLE_AFTER_ERROR = 4'd11;

   // Sticky error codes.
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NO_SLASH  = 3'd1;
   localparam logic [2:0] ERR_NO_COMMA  = 3'd2;
   localparam logic [2:0] ERR_BAD_TAG   = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED = 3'd4;
   localparam logic [2:0] ERR_TOO_MANY  = 3'd5;

   // Argument kinds as stored per tag.
   localparam logic [1:0] KIND_INT32   = 2'd0;
   localparam logic [1:0] KIND_FLOAT32 = 2'd1;
   localparam logic [1:0] KIND_STRING  = 2'd2;
   localparam logic [1:0] KIND_BLOB    = 2'd3;

   // Marker characters.
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_S     = 8'h73;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // One labelled result word.
   typedef struct packed {
      logic [7:0]  byte_out;
      logic [3:0]  role;
      logic [3:0]  arg_index;
      logic [1:0]  arg_kind;
      logic [31:0] word_value;
      logic        word_valid;
      logic        message_done;
      logic        message_ok;
      logic [2:0]  error_code;
   } result_type;

endpackage

### rtl/oscmp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the tag store of the OSC parser. No dependencies.
module oscmp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### rtl/osc_message_stream_parser.sv
// Top level of the OSC message stream parser: byte-wise phase tracking,
// labelling and result buffering. Depends on oscmp_pkg and oscmp_ram.

// The parser takes one OSC message byte per word on the req_ channel, with
// req_tlast on the final byte, and returns one labelled word per byte on the
// rsp_ channel. The phase update is a short step of logic from the held
// parser state to a result register, so a new byte can be accepted on every
// clock while the skid register is empty. A two-entry output stage (result
// register plus skid register) keeps req_tready high while one finished
// result waits to be taken. Tag kinds are kept in a small RAM of MAX_ARGS
// entries that is read one byte ahead, so argument bytes see their kind
// without a read stall. The first error sticks until the final byte, which
// reports success or the error code and returns the parser to the start of
// a new message.
module osc_message_stream_parser #(
   parameter int MAX_ARGS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] byte_out, [11:8] arg_index,
                                    // [43:12] word_value, [44] word_valid,
                                    // [45] message_ok, [48:46] error_code,
                                    // [55:49] zero
   output logic [5:0]  rsp_tuser,   // [3:0] role, [5:4] arg_kind
   output logic        rsp_tlast    // message_done
);
   import oscmp_pkg::*;

   localparam int CW = $clog2(MAX_ARGS + 1);
   localparam int AW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
   localparam logic [CW-1:0] MAX_TAGS = CW'(MAX_ARGS);

   typedef enum logic [3:0] {
      PH_ADDR_START, PH_ADDR, PH_ADDR_PAD, PH_TAG_START, PH_TAG, PH_TAG_PAD,
      PH_ARG_START, PH_NUM, PH_STR, PH_STR_PAD, PH_BLOB_LEN, PH_BLOB_DATA,
      PH_BLOB_PAD, PH_TRAILING, PH_ERROR
   } phase_type;

   // Parser state.
   phase_type     phase_ff, phase_in, phase_eff;
   logic [CW-1:0] tag_count_ff, tag_count_in;
   logic [CW-1:0] cur_arg_ff, cur_arg_in;
   logic [1:0]    offset_ff, offset_in;
   logic [31:0]   blob_rem_ff, blob_rem_in;
   logic [31:0]   word_shift_ff, word_shift_in;
   logic [1:0]    word_cnt_ff, word_cnt_in;
   logic [2:0]    error_ff, error_in;

   // Output stage.
   result_type    result_in, out_ff, skid_ff;
   logic          out_valid_ff, skid_valid_ff;

   // Tag store.
   logic          tag_we;
   logic [1:0]    tag_kind, rd_kind;
   logic          tag_known;

   logic          accept, out_free;
   logic [CW-1:0] arg_plus_one;
   logic [31:0]   word_next;
   logic [31:0]   blob_dec;
   phase_type     next_arg_phase, first_arg_phase;
   logic [CW+3:0] cur_arg_ext, tag_count_ext;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign arg_plus_one    = cur_arg_ff + CW'(1);
   assign next_arg_phase  = (arg_plus_one >= tag_count_ff) ? PH_TRAILING : PH_ARG_START;
   assign first_arg_phase = (tag_count_ff == '0) ? PH_TRAILING : PH_ARG_START;
   assign word_next       = {word_shift_ff[23:0], req_tdata};
   assign blob_dec        = blob_rem_ff - 32'd1;
   assign cur_arg_ext     = {4'b0000, cur_arg_ff};
   assign tag_count_ext   = {4'b0000, tag_count_ff};

   always_comb begin
      tag_known = 1'b1;
      unique case (req_tdata)
         CHAR_I:  tag_kind = KIND_INT32;
         CHAR_F:  tag_kind = KIND_FLOAT32;
         CHAR_S:  tag_kind = KIND_STRING;
         CHAR_B:  tag_kind = KIND_BLOB;
         default: begin
            tag_kind  = KIND_INT32;
            tag_known = 1'b0;
         end
      endcase
   end

   // The first byte of an argument takes its phase from the stored kind.
   always_comb begin
      if (phase_ff == PH_ARG_START) begin
         unique case (rd_kind)
            KIND_STRING: phase_eff = PH_STR;
            KIND_BLOB:   phase_eff = PH_BLOB_LEN;
            default:     phase_eff = PH_NUM;
         endcase
      end else begin
         phase_eff = phase_ff;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      tag_count_in  = tag_count_ff;
      cur_arg_in    = cur_arg_ff;
      offset_in     = offset_ff + 2'd1;
      blob_rem_in   = blob_rem_ff;
      word_shift_in = word_shift_ff;
      word_cnt_in   = word_cnt_ff;
      error_in      = error_ff;
      tag_we        = 1'b0;

      result_in              = '0;
      result_in.byte_out     = req_tdata;
      result_in.role         = ROLE_AFTER_ERROR;

      if (phase_eff == PH_NUM || phase_eff == PH_STR || phase_eff == PH_STR_PAD ||
          phase_eff == PH_BLOB_LEN || phase_eff == PH_BLOB_DATA ||
          phase_eff == PH_BLOB_PAD) begin
         result_in.arg_index = cur_arg_ext[3:0];
         result_in.arg_kind  = rd_kind;
      end

      unique case (phase_eff)
         PH_ADDR_START: begin
            result_in.role = ROLE_ADDR;
            if (req_tdata == CHAR_SLASH) begin
               phase_in = PH_ADDR;
            end else begin
               if (error_ff == ERR_NONE) error_in = ERR_NO_SLASH;
               phase_in = PH_ERROR;
            end
         end
         PH_ADDR: begin
            if (req_tdata == CHAR_NUL) begin
               result_in.role = ROLE_ADDR_PAD;
               phase_in = (offset_in == 2'd0) ? PH_TAG_START : PH_ADDR_PAD;
            end else begin
               result_in.role = ROLE_ADDR;
            end
         end
         PH_ADDR_PAD: begin
            result_in.role = ROLE_ADDR_PAD;
            if (offset_in == 2'd0) phase_in = PH_TAG_START;
         end
         PH_TAG_START: begin
            result_in.role = ROLE_TAG;
            if (req_tdata == CHAR_COMMA) begin
               phase_in = PH_TAG;
            end else begin
               if (error_ff == ERR_NONE) error_in = ERR_NO_COMMA;
               phase_in = PH_ERROR;
            end
         end
         PH_TAG: begin
            if (req_tdata == CHAR_NUL) begin
               result_in.role = ROLE_TAG_PAD;
               if (offset_in == 2'd0) begin
                  cur_arg_in    = '0;
                  word_shift_in = '0;
                  word_cnt_in   = '0;
                  phase_in      = first_arg_phase;
               end else begin
                  phase_in = PH_TAG_PAD;
               end
            end else begin
               result_in.role      = ROLE_TAG;
               result_in.arg_index = tag_count_ext[3:0];
               if (tag_count_ff >= MAX_TAGS) begin
                  if (error_ff == ERR_NONE) error_in = ERR_TOO_MANY;
                  phase_in = PH_ERROR;
               end else if (!tag_known) begin
                  if (error_ff == ERR_NONE) error_in = ERR_BAD_TAG;
                  phase_in = PH_ERROR;
               end else begin
                  tag_we             = 1'b1;
                  result_in.arg_kind = tag_kind;
                  tag_count_in       = tag_count_ff + CW'(1);
               end
            end
         end
         PH_TAG_PAD: begin
            result_in.role = ROLE_TAG_PAD;
            if (offset_in == 2'd0) begin
               cur_arg_in    = '0;
               word_shift_in = '0;
               word_cnt_in   = '0;
               phase_in      = first_arg_phase;
            end
         end
         PH_NUM, PH_BLOB_LEN: begin
            result_in.role = (phase_eff == PH_NUM) ? ROLE_NUM : ROLE_BLOB_LEN;
            word_shift_in  = word_next;
            if (word_cnt_ff == 2'd3) begin
               result_in.word_value = word_next;
               result_in.word_valid = 1'b1;
               word_cnt_in          = '0;
               if (phase_eff == PH_BLOB_LEN && word_next != 32'd0) begin
                  blob_rem_in = word_next;
                  phase_in    = PH_BLOB_DATA;
               end else begin
                  if (phase_eff == PH_BLOB_LEN) blob_rem_in = word_next;
                  cur_arg_in    = arg_plus_one;
                  word_shift_in = '0;
                  phase_in      = next_arg_phase;
               end
            end else begin
               word_cnt_in = word_cnt_ff + 2'd1;
               // Past the first byte the phase must stay explicit.
               phase_in    = phase_eff;
            end
         end
         PH_STR: begin
            if (req_tdata == CHAR_NUL) begin
               result_in.role = ROLE_STR_PAD;
               if (offset_in == 2'd0) begin
                  cur_arg_in    = arg_plus_one;
                  word_shift_in = '0;
                  word_cnt_in   = '0;
                  phase_in      = next_arg_phase;
               end else begin
                  phase_in = PH_STR_PAD;
               end
            end else begin
               result_in.role = ROLE_STR;
               phase_in       = PH_STR;
            end
         end
         PH_STR_PAD, PH_BLOB_PAD: begin
            result_in.role = (phase_eff == PH_STR_PAD) ? ROLE_STR_PAD : ROLE_BLOB_PAD;
            if (offset_in == 2'd0) begin
               cur_arg_in    = arg_plus_one;
               word_shift_in = '0;
               word_cnt_in   = '0;
               phase_in      = next_arg_phase;
            end
         end
         PH_BLOB_DATA: begin
            result_in.role = ROLE_BLOB_DATA;
            blob_rem_in    = blob_dec;
            if (blob_dec == 32'd0) begin
               if (offset_in == 2'd0) begin
                  cur_arg_in    = arg_plus_one;
                  word_shift_in = '0;
                  word_cnt_in   = '0;
                  phase_in      = next_arg_phase;
               end else begin
                  phase_in = PH_BLOB_PAD;
               end
            end
         end
         PH_TRAILING: begin
            result_in.role = ROLE_TRAILING;
         end
         default: begin
            result_in.role = ROLE_AFTER_ERROR;
            phase_in       = PH_ERROR;
         end
      endcase

      // The final byte reports the outcome and rearms for the next message.
      if (req_tlast) begin
         if (error_in == ERR_NONE && phase_in != PH_TRAILING) error_in = ERR_TRUNCATED;
         result_in.message_done = 1'b1;
         result_in.message_ok   = (error_in == ERR_NONE);
      end
      result_in.error_code = error_in;
      if (req_tlast) begin
         phase_in      = PH_ADDR_START;
         tag_count_in  = '0;
         cur_arg_in    = '0;
         offset_in     = '0;
         blob_rem_in   = '0;
         word_shift_in = '0;
         word_cnt_in   = '0;
         error_in      = ERR_NONE;
      end
   end

   // The read address follows the argument index one byte ahead, so the
   // registered read data always belongs to the argument now in progress.
   oscmp_ram #(
      .WIDTH (2),
      .DEPTH (MAX_ARGS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (accept && tag_we),
      .wr_addr (tag_count_ff[AW-1:0]),
      .wr_data (tag_kind),
      .rd_addr (accept ? cur_arg_in[AW-1:0] : cur_arg_ff[AW-1:0]),
      .rd_data (rd_kind)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_ADDR_START;
         tag_count_ff  <= '0;
         cur_arg_ff    <= '0;
         offset_ff     <= '0;
         blob_rem_ff   <= '0;
         word_shift_ff <= '0;
         word_cnt_ff   <= '0;
         error_ff      <= ERR_NONE;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            tag_count_ff  <= tag_count_in;
            cur_arg_ff    <= cur_arg_in;
            offset_ff     <= offset_in;
            blob_rem_ff   <= blob_rem_in;
            word_shift_ff <= word_shift_in;
            word_cnt_ff   <= word_cnt_in;
            error_ff      <= error_in;
         end
         if (out_free) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_ff       <= result_in;
               out_valid_ff <= accept;
            end
         end else if (accept) begin
            skid_ff       <= result_in;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.message_done;
   assign rsp_tuser  = {out_ff.arg_kind, out_ff.role};
   assign rsp_tdata  = {7'b0000000, out_ff.error_code, out_ff.message_ok,
                        out_ff.word_valid, out_ff.word_value, out_ff.arg_index,
                        out_ff.byte_out};

`ifndef SYNTHESIS
   // A word waits in the skid register only behind a word in the result register.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a word while the result register is empty");

   // The argument walk never passes the number of stored tags.
   assert property (@(posedge clock) disable iff (reset) cur_arg_ff <= tag_count_ff)
      else $error("argument index beyond tag count");

   // The final byte of a message always rearms the parser.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> phase_ff == PH_ADDR_START && error_ff == ERR_NONE)
      else $error("parser not rearmed after final byte");

   // A completed word is only reported for numeric or blob length bytes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.word_valid |->
         out_ff.role == ROLE_NUM || out_ff.role == ROLE_BLOB_LEN)
      else $error("word reported on a byte that is not numeric or blob length");
`endif

endmodule
